/* sv/krt_pkg.sv */
// krt_pkg: shared constants for the keyed record table
// table geometry, record layout, command and status codes; no dependencies
package krt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int NAME_BITS   = 64;
  localparam int COORD_BITS  = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int REC_W       = NAME_BITS + 2 * COORD_BITS;
  localparam int FILL_W      = 7;

  localparam logic [2:0] CMD_INSERT      = 3'd0;
  localparam logic [2:0] CMD_DEL_NAME    = 3'd1;
  localparam logic [2:0] CMD_DEL_COORD   = 3'd2;
  localparam logic [2:0] CMD_SRCH_NAME   = 3'd3;
  localparam logic [2:0] CMD_SRCH_COORD  = 3'd4;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

endpackage

/* sv/krt_ram.sv */
// krt_ram: generic single-write, single-read memory with registered read data
// no package dependency
module krt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/keyed_record_table_unit.sv */
// keyed_record_table_unit: unsorted record table with linear search and shift-down delete
// depends on krt_pkg and krt_ram
// sequence: insert, bad command and empty-table cases go from accept straight to the result;
//   a search reads, then compares each entry in turn through the one ram port, up to a hit,
//   and a delete then shifts every record above the hit down one place
// throughput: one command at a time; in_ready is high only while the sequencer is idle
// reset: synchronous active-low rst_n clears the count, sequencer and output valid;
//   the record memory is not cleared since only entries below the count are ever read
module keyed_record_table_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_command,
  input  logic [63:0]         in_name_key,
  input  logic signed [15:0]  in_x_coord,
  input  logic signed [15:0]  in_y_coord,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_success,
  output logic [1:0]          out_status,
  output logic [6:0]          out_fill_count
);

  // one-hot sequencer states
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RD    = 6'b000010,
    S_CMP   = 6'b000100,
    S_SH_WR = 6'b001000,
    S_DONE  = 6'b010000,
    S_HOLD  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [krt_pkg::CNT_W-1:0]     count_r, count_nxt;
  logic [krt_pkg::CNT_W-1:0]     idx_r, idx_nxt;
  logic [2:0]                    cmd_r;
  logic [krt_pkg::NAME_BITS-1:0] key_r;
  logic [krt_pkg::COORD_BITS-1:0] x_r, y_r;

  // pending result, parked until the output register is free
  logic                          res_success_r, res_success_nxt;
  logic [1:0]                    res_status_r, res_status_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic                          out_success_r, out_success_nxt;
  logic [1:0]                    out_status_r, out_status_nxt;
  logic [krt_pkg::FILL_W-1:0]    out_fill_r, out_fill_nxt;

  // ram side
  logic                          ram_we;
  logic [krt_pkg::IDX_W-1:0]     ram_waddr, ram_raddr;
  logic [krt_pkg::REC_W-1:0]     ram_wdata, ram_rdata;

  logic                          in_fire;
  logic                          by_name, is_delete;
  logic                          hit;
  logic [krt_pkg::CNT_W:0]       idx_p1, idx_p2;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_success    = out_success_r;
  assign out_status     = out_status_r;
  assign out_fill_count = out_fill_r;

  assign by_name   = (cmd_r == krt_pkg::CMD_DEL_NAME) || (cmd_r == krt_pkg::CMD_SRCH_NAME);
  assign is_delete = (cmd_r == krt_pkg::CMD_DEL_NAME) || (cmd_r == krt_pkg::CMD_DEL_COORD);

  // record layout: name on top, then x, then y
  assign hit = by_name
             ? (ram_rdata[krt_pkg::REC_W-1 -: krt_pkg::NAME_BITS] == key_r)
             : ((ram_rdata[2*krt_pkg::COORD_BITS-1 -: krt_pkg::COORD_BITS] == x_r) &&
                (ram_rdata[krt_pkg::COORD_BITS-1:0] == y_r));

  assign idx_p1 = {1'b0, idx_r} + (krt_pkg::CNT_W+1)'(1);
  assign idx_p2 = {1'b0, idx_r} + (krt_pkg::CNT_W+1)'(2);

  krt_ram #(
    .WIDTH (krt_pkg::REC_W),
    .DEPTH (krt_pkg::TABLE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    idx_nxt         = idx_r;
    res_success_nxt = res_success_r;
    res_status_nxt  = res_status_r;
    out_valid_nxt   = out_valid_r;
    out_success_nxt = out_success_r;
    out_status_nxt  = out_status_r;
    out_fill_nxt    = out_fill_r;
    ram_we          = 1'b0;
    ram_waddr       = idx_r[krt_pkg::IDX_W-1:0];
    ram_wdata       = ram_rdata;
    ram_raddr       = idx_r[krt_pkg::IDX_W-1:0];

    // output word taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          idx_nxt   = '0;
          state_nxt = S_DONE;
          if (in_command == krt_pkg::CMD_INSERT) begin
            if (count_r >= krt_pkg::CNT_W'(krt_pkg::TABLE_DEPTH)) begin
              res_success_nxt = 1'b0;
              res_status_nxt  = krt_pkg::ST_FULL;
            end else begin
              // append at the end of the table
              ram_we    = 1'b1;
              ram_waddr = count_r[krt_pkg::IDX_W-1:0];
              ram_wdata = {in_name_key[krt_pkg::NAME_BITS-1:0], in_x_coord, in_y_coord};
              count_nxt = count_r + krt_pkg::CNT_W'(1);
              res_success_nxt = 1'b1;
              res_status_nxt  = krt_pkg::ST_DONE;
            end
          end else if (in_command > krt_pkg::CMD_SRCH_COORD) begin
            // unused codes: no change
            res_success_nxt = 1'b0;
            res_status_nxt  = krt_pkg::ST_DONE;
          end else if (count_r == '0) begin
            res_success_nxt = 1'b0;
            res_status_nxt  = krt_pkg::ST_EMPTY;
          end else begin
            state_nxt = S_RD;
          end
        end
      end

      S_RD: begin
        // address idx_r is on the read port; data lands next cycle
        state_nxt = S_CMP;
      end

      S_CMP: begin
        if (hit) begin
          if (!is_delete) begin
            res_success_nxt = 1'b1;
            res_status_nxt  = krt_pkg::ST_DONE;
            state_nxt       = S_DONE;
          end else if (idx_p1 < {1'b0, count_r}) begin
            // start the shift: fetch the record above the hole
            ram_raddr = idx_p1[krt_pkg::IDX_W-1:0];
            state_nxt = S_SH_WR;
          end else begin
            // last record removed, nothing to shift
            count_nxt       = count_r - krt_pkg::CNT_W'(1);
            res_success_nxt = 1'b1;
            res_status_nxt  = krt_pkg::ST_DONE;
            state_nxt       = S_DONE;
          end
        end else if (idx_p1 >= {1'b0, count_r}) begin
          res_success_nxt = 1'b0;
          res_status_nxt  = krt_pkg::ST_MISSING;
          state_nxt       = S_DONE;
        end else begin
          idx_nxt   = idx_p1[krt_pkg::CNT_W-1:0];
          state_nxt = S_RD;
        end
      end

      S_SH_WR: begin
        // move record idx+1 down into idx while fetching idx+2
        ram_we    = 1'b1;
        ram_waddr = idx_r[krt_pkg::IDX_W-1:0];
        ram_wdata = ram_rdata;
        idx_nxt   = idx_p1[krt_pkg::CNT_W-1:0];
        if (idx_p2 < {1'b0, count_r}) begin
          ram_raddr = idx_p2[krt_pkg::IDX_W-1:0];
        end else begin
          count_nxt       = count_r - krt_pkg::CNT_W'(1);
          res_success_nxt = 1'b1;
          res_status_nxt  = krt_pkg::ST_DONE;
          state_nxt       = S_DONE;
        end
      end

      S_DONE: begin
        state_nxt = S_HOLD;
      end

      S_HOLD: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_success_nxt = res_success_r;
          out_status_nxt  = res_status_r;
          out_fill_nxt    = krt_pkg::FILL_W'(count_r);
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    idx_r         <= idx_nxt;
    res_success_r <= res_success_nxt;
    res_status_r  <= res_status_nxt;
    out_success_r <= out_success_nxt;
    out_status_r  <= out_status_nxt;
    out_fill_r    <= out_fill_nxt;
    if (in_fire) begin
      cmd_r <= in_command;
      key_r <= in_name_key[krt_pkg::NAME_BITS-1:0];
      x_r   <= in_x_coord;
      y_r   <= in_y_coord;
    end
  end

endmodule
